FILE: hdl/fbre_pkg.sv
// ----------------------------------------------------------------------------
// fbre_pkg: shared types, constants and font table for the raster engine
// Holds command codes, controller/datapath command and status structs and
// the 5x7 glyph font.
// ----------------------------------------------------------------------------
package fbre_pkg;

    localparam int DEF_SCREEN_W = 128;
    localparam int DEF_SCREEN_H = 64;

    localparam logic [3:0] KIND_CLEAR    = 4'd0;
    localparam logic [3:0] KIND_SET      = 4'd1;
    localparam logic [3:0] KIND_RESET    = 4'd2;
    localparam logic [3:0] KIND_LINE     = 4'd3;
    localparam logic [3:0] KIND_RECT     = 4'd4;
    localparam logic [3:0] KIND_FRECT    = 4'd5;
    localparam logic [3:0] KIND_CIRCLE   = 4'd6;
    localparam logic [3:0] KIND_FCIRCLE  = 4'd7;
    localparam logic [3:0] KIND_GLYPH    = 4'd8;
    localparam logic [3:0] KIND_READ     = 4'd9;

    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_LAST  = 8'd126;

    // span generator modes
    localparam logic [1:0] SPAN_H = 2'd0;
    localparam logic [1:0] SPAN_V = 2'd1;
    localparam logic [1:0] SPAN_G = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic        load;       // latch command fields
        logic        clr_init;
        logic        span_go;    // start a span
        logic [1:0]  span_mode;
        logic signed [12:0] sx;
        logic signed [12:0] sy;
        logic [10:0] slen;
        logic        px_go;      // single pixel op
        logic        px_on;
        logic        line_init;
        logic        line_step;
        logic        circ_init;
        logic        circ_step;
        logic        rd_go;
        logic        done;
    } fbre_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic        clr_last;
        logic        span_busy;
        logic        pix_busy;
        logic        line_last;
        logic        circ_more;
        logic signed [12:0] cpx;
        logic signed [12:0] cpy;
        logic signed [12:0] cx;
        logic signed [12:0] cy;
        logic signed [12:0] xa;
        logic signed [12:0] ya;
        logic [8:0]  w;
        logic [8:0]  h;
        logic [3:0]  kind;
    } fbre_stat_t;

    function automatic logic [39:0] font_row(input logic [7:0] c);
        logic [6:0] i;
        i = (c < GLYPH_FIRST || c > GLYPH_LAST) ? 7'd0 : 7'(c - GLYPH_FIRST);
        case (i)
            7'd0:  font_row = 40'h0000000000; 7'd1:  font_row = 40'h00005F0000;
            7'd2:  font_row = 40'h0007000700; 7'd3:  font_row = 40'h147F147F14;
            7'd4:  font_row = 40'h242A7F2A12; 7'd5:  font_row = 40'h2313086462;
            7'd6:  font_row = 40'h3649552250; 7'd7:  font_row = 40'h0005030000;
            7'd8:  font_row = 40'h001C224100; 7'd9:  font_row = 40'h0041221C00;
            7'd10: font_row = 40'h082A1C2A08; 7'd11: font_row = 40'h08083E0808;
            7'd12: font_row = 40'h0050300000; 7'd13: font_row = 40'h0808080808;
            7'd14: font_row = 40'h0060600000; 7'd15: font_row = 40'h2010080402;
            7'd16: font_row = 40'h3E5149453E; 7'd17: font_row = 40'h00427F4000;
            7'd18: font_row = 40'h4261514946; 7'd19: font_row = 40'h2141454B31;
            7'd20: font_row = 40'h1814127F10; 7'd21: font_row = 40'h2745454539;
            7'd22: font_row = 40'h3C4A494930; 7'd23: font_row = 40'h0171090503;
            7'd24: font_row = 40'h3649494936; 7'd25: font_row = 40'h064949291E;
            7'd26: font_row = 40'h0036360000; 7'd27: font_row = 40'h0056360000;
            7'd28: font_row = 40'h0008142241; 7'd29: font_row = 40'h1414141414;
            7'd30: font_row = 40'h4122140800; 7'd31: font_row = 40'h0201510906;
            7'd32: font_row = 40'h324979413E; 7'd33: font_row = 40'h7E1111117E;
            7'd34: font_row = 40'h7F49494936; 7'd35: font_row = 40'h3E41414122;
            7'd36: font_row = 40'h7F4141221C; 7'd37: font_row = 40'h7F49494941;
            7'd38: font_row = 40'h7F09090101; 7'd39: font_row = 40'h3E41415132;
            7'd40: font_row = 40'h7F0808087F; 7'd41: font_row = 40'h00417F4100;
            7'd42: font_row = 40'h2040413F01; 7'd43: font_row = 40'h7F08142241;
            7'd44: font_row = 40'h7F40404040; 7'd45: font_row = 40'h7F0204027F;
            7'd46: font_row = 40'h7F0408107F; 7'd47: font_row = 40'h3E4141413E;
            7'd48: font_row = 40'h7F09090906; 7'd49: font_row = 40'h3E4151215E;
            7'd50: font_row = 40'h7F09192946; 7'd51: font_row = 40'h4649494931;
            7'd52: font_row = 40'h01017F0101; 7'd53: font_row = 40'h3F4040403F;
            7'd54: font_row = 40'h1F2040201F; 7'd55: font_row = 40'h7F2018207F;
            7'd56: font_row = 40'h6314081463; 7'd57: font_row = 40'h0304780403;
            7'd58: font_row = 40'h6151494543; 7'd59: font_row = 40'h00007F4141;
            7'd60: font_row = 40'h0204081020; 7'd61: font_row = 40'h41417F0000;
            7'd62: font_row = 40'h0402010204; 7'd63: font_row = 40'h4040404040;
            7'd64: font_row = 40'h0001020400; 7'd65: font_row = 40'h2054545478;
            7'd66: font_row = 40'h7F48444438; 7'd67: font_row = 40'h3844444420;
            7'd68: font_row = 40'h384444487F; 7'd69: font_row = 40'h3854545418;
            7'd70: font_row = 40'h087E090102; 7'd71: font_row = 40'h081454543C;
            7'd72: font_row = 40'h7F08040478; 7'd73: font_row = 40'h00447D4000;
            7'd74: font_row = 40'h2040443D00; 7'd75: font_row = 40'h007F102844;
            7'd76: font_row = 40'h00417F4000; 7'd77: font_row = 40'h7C04180478;
            7'd78: font_row = 40'h7C08040478; 7'd79: font_row = 40'h3844444438;
            7'd80: font_row = 40'h7C14141408; 7'd81: font_row = 40'h081414187C;
            7'd82: font_row = 40'h7C08040408; 7'd83: font_row = 40'h4854545420;
            7'd84: font_row = 40'h043F444020; 7'd85: font_row = 40'h3C4040207C;
            7'd86: font_row = 40'h1C2040201C; 7'd87: font_row = 40'h3C4030403C;
            7'd88: font_row = 40'h4428102844; 7'd89: font_row = 40'h0C5050503C;
            7'd90: font_row = 40'h4464544C44; 7'd91: font_row = 40'h0008364100;
            7'd92: font_row = 40'h00007F0000; 7'd93: font_row = 40'h0041360800;
            7'd94: font_row = 40'h08082A1C08;
            default: font_row = 40'h0000000000;
        endcase
    endfunction

endpackage

FILE: hdl/framebuffer_raster_engine.sv
// ----------------------------------------------------------------------------
// framebuffer_raster_engine: monochrome page framebuffer drawing engine
// Clears, plots, draws lines, rectangles, circles and glyphs, reads bytes.
//
//   channel   dir   signals                              when
//   command   in    start, kind, x_a..byte_index        start && !busy
//   result    out   strobe, read_data                   strobe, one cycle
//
// Each drawn on-screen pixel is a read-modify-write on the byte store;
// off-screen or blank glyph cells are skipped without a write. Clear
// zeroes all SCREEN_W*((SCREEN_H+7)/8) bytes of the store.
// After reset the store is swept to zero in the same way with busy high.
// One strobe ends each command; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module framebuffer_raster_engine
    import fbre_pkg::*;
#(
    parameter int SCREEN_W = DEF_SCREEN_W,
    parameter int SCREEN_H = DEF_SCREEN_H
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  kind,
    input  logic signed [9:0] x_a,
    input  logic signed [9:0] y_a,
    input  logic signed [9:0] x_b,
    input  logic signed [9:0] y_b,
    input  logic [8:0]  extent_w,
    input  logic [8:0]  extent_h,
    input  logic [7:0]  radius,
    input  logic [7:0]  char_code,
    input  logic [9:0]  byte_index,
    output logic        strobe,
    output logic [7:0]  read_data
);

    fbre_cmd_t  cmd;
    fbre_stat_t stat;

    // sequencer
    fbre_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // store and steppers
    fbre_datapath #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .x_a        (x_a),
        .y_a        (y_a),
        .x_b        (x_b),
        .y_b        (y_b),
        .extent_w   (extent_w),
        .extent_h   (extent_h),
        .radius     (radius),
        .char_code  (char_code),
        .byte_index (byte_index),
        .read_data  (read_data),
        .strobe     (strobe)
    );

endmodule

FILE: hdl/fbre_datapath.sv
// ----------------------------------------------------------------------------
// fbre_datapath: framebuffer memory, pixel unit and stepping engines
// Holds the command fields, the byte store with a read-modify-write pixel
// unit, the span walker, Bresenham and midpoint circle steppers.
// ----------------------------------------------------------------------------
module fbre_datapath
    import fbre_pkg::*;
#(
    parameter int SCREEN_W = DEF_SCREEN_W,
    parameter int SCREEN_H = DEF_SCREEN_H
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fbre_cmd_t   cmd,
    output fbre_stat_t  stat,
    input  logic [3:0]  kind,
    input  logic signed [9:0] x_a,
    input  logic signed [9:0] y_a,
    input  logic signed [9:0] x_b,
    input  logic signed [9:0] y_b,
    input  logic [8:0]  extent_w,
    input  logic [8:0]  extent_h,
    input  logic [7:0]  radius,
    input  logic [7:0]  char_code,
    input  logic [9:0]  byte_index,
    output logic [7:0]  read_data,
    output logic        strobe
);

    localparam int PAGES = (SCREEN_H + 7) / 8;
    localparam int BYTES = SCREEN_W * PAGES;
    localparam int AW    = $clog2(BYTES);

    logic [7:0] mem [BYTES];

    // latched command fields
    logic [3:0]  kind_reg;
    logic signed [12:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [8:0]  w_reg, h_reg;
    logic [7:0]  rad_reg;
    logic [39:0] font_reg;
    logic [9:0]  bidx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            xa_reg   <= 13'(x_a);
            ya_reg   <= 13'(y_a);
            xb_reg   <= 13'(x_b);
            yb_reg   <= 13'(y_b);
            w_reg    <= extent_w;
            h_reg    <= extent_h;
            rad_reg  <= radius;
            font_reg <= font_row(char_code);
            bidx_reg <= byte_index;
        end
    end

    // pixel request from span walker, line, single pixel
    logic               preq;
    logic               pon;
    logic signed [12:0] pxx, pyy;

    // span walker
    logic               sp_act_reg;
    logic [1:0]         sp_mode_reg;
    logic signed [12:0] sp_x_reg, sp_y_reg;
    logic [10:0]        sp_cnt_reg;
    logic [10:0]        sp_len_reg;
    logic               sp_hit;

    // pixel rmw pipe: read then write
    logic               pw_act_reg;
    logic               pw_on_reg;
    logic [AW-1:0]      pw_addr_reg;
    logic [2:0]         pw_bit_reg;
    logic [7:0]         rdat_reg;
    logic               pw_busy;

    // clear sweep
    logic [AW:0]        clr_reg;

    // line stepper
    logic signed [12:0] lx_reg, ly_reg, ldx_reg, ldy_reg;
    logic signed [13:0] lerr_reg;
    logic               lsx_reg, lsy_reg;

    // circle stepper
    logic signed [12:0] cf_reg, cddx_reg, cddy_reg, cpx_reg, cpy_reg;

    // read result
    logic [7:0]         rd_reg;
    logic               strobe_reg;
    logic               rd_pend_reg;

    logic               in_screen;
    logic [AW-1:0]      p_addr;
    logic signed [12:0] pyy_pg;

    // span walker step
    always_comb
    begin
        sp_hit = 1'b0;
        if (sp_mode_reg == SPAN_G)
        begin
            sp_hit = font_reg[6'(39 - 8 * (32'(sp_cnt_reg) >> 3)
                                - (7 - (32'(sp_cnt_reg) & 7)))];
        end
        else
        begin
            sp_hit = 1'b1;
        end
    end

    // pixel request mux
    always_comb
    begin
        preq = 1'b0;
        pon  = 1'b1;
        pxx  = '0;
        pyy  = '0;
        if (sp_act_reg)
        begin
            preq = sp_hit;
            if (sp_mode_reg == SPAN_H)
            begin
                pxx = sp_x_reg + 13'(sp_cnt_reg);
                pyy = sp_y_reg;
            end
            else if (sp_mode_reg == SPAN_V)
            begin
                pxx = sp_x_reg;
                pyy = sp_y_reg + 13'(sp_cnt_reg);
            end
            else
            begin
                pxx = sp_x_reg + 13'(sp_cnt_reg[10:3]);
                pyy = sp_y_reg + 13'(sp_cnt_reg[2:0]);
            end
        end
        else if (cmd.line_step)
        begin
            preq = 1'b1;
            pxx  = lx_reg;
            pyy  = ly_reg;
        end
        else if (cmd.px_go)
        begin
            preq = 1'b1;
            pon  = cmd.px_on;
            pxx  = cmd.sx;
            pyy  = cmd.sy;
        end
    end

    assign in_screen = (pxx >= 0) && (pxx < 13'(SCREEN_W)) && (pyy >= 0)
                       && (pyy < 13'(SCREEN_H));
    assign pyy_pg    = pyy >>> 3;
    assign p_addr    = AW'(pxx) + AW'(pyy_pg) * AW'(SCREEN_W);
    assign pw_busy   = pw_act_reg;

    // memory: one read port, one write port, registered read
    always_ff @(posedge clk)
    begin
        if (clr_reg != '0)
        begin
            mem[AW'(clr_reg - 1'b1)] <= 8'h00;
        end
        else if (pw_act_reg)
        begin
            if (pw_on_reg)
            begin
                mem[pw_addr_reg] <= rdat_reg | (8'h01 << pw_bit_reg);
            end
            else
            begin
                mem[pw_addr_reg] <= rdat_reg & ~(8'h01 << pw_bit_reg);
            end
        end
        // read data holds until the next pixel or byte read
        if (cmd.rd_go)
        begin
            rdat_reg <= mem[AW'(bidx_reg)];
        end
        else if (preq)
        begin
            rdat_reg <= mem[p_addr];
        end
    end

    // pixel rmw: a request issues only when no write is pending
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_act_reg <= 1'b0;
        end
        else
        begin
            pw_act_reg <= preq && in_screen && !pw_act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_on_reg   <= pon;
        pw_addr_reg <= p_addr;
        pw_bit_reg  <= pyy[2:0];
    end

    // span walker, stalls only while a write is pending and the current cell is an on-screen hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_act_reg <= 1'b0;
            sp_cnt_reg <= '0;
        end
        else if (cmd.span_go)
        begin
            sp_act_reg  <= (cmd.slen != '0);
            sp_mode_reg <= cmd.span_mode;
            sp_x_reg    <= cmd.sx;
            sp_y_reg    <= cmd.sy;
            sp_len_reg  <= cmd.slen;
            sp_cnt_reg  <= '0;
        end
        else if (sp_act_reg && !(pw_act_reg && sp_hit && in_screen))
        begin
            if (sp_cnt_reg == sp_len_reg - 1'b1)
            begin
                sp_act_reg <= 1'b0;
            end
            sp_cnt_reg <= sp_cnt_reg + 1'b1;
        end
    end

    // clear sweep over the whole store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= (AW+1)'(BYTES);
        end
        else if (cmd.clr_init)
        begin
            clr_reg <= (AW+1)'(BYTES);
        end
        else if (clr_reg != '0)
        begin
            clr_reg <= clr_reg - 1'b1;
        end
    end

    // bresenham line stepper
    logic signed [13:0] le2;
    assign le2 = lerr_reg <<< 1;

    always_ff @(posedge clk)
    begin
        if (cmd.line_init)
        begin
            lx_reg   <= xa_reg;
            ly_reg   <= ya_reg;
            ldx_reg  <= (xb_reg > xa_reg) ? xb_reg - xa_reg : xa_reg - xb_reg;
            ldy_reg  <= (yb_reg > ya_reg) ? yb_reg - ya_reg : ya_reg - yb_reg;
            lerr_reg <= 14'((xb_reg > xa_reg) ? xb_reg - xa_reg : xa_reg - xb_reg)
                      - 14'((yb_reg > ya_reg) ? yb_reg - ya_reg : ya_reg - yb_reg);
            lsx_reg  <= xa_reg < xb_reg;
            lsy_reg  <= ya_reg < yb_reg;
        end
        else if (cmd.line_step)
        begin
            if (le2 > -14'(ldy_reg) && le2 < 14'(ldx_reg))
            begin
                lerr_reg <= lerr_reg - 14'(ldy_reg) + 14'(ldx_reg);
            end
            else if (le2 > -14'(ldy_reg))
            begin
                lerr_reg <= lerr_reg - 14'(ldy_reg);
            end
            else if (le2 < 14'(ldx_reg))
            begin
                lerr_reg <= lerr_reg + 14'(ldx_reg);
            end
            if (le2 > -14'(ldy_reg))
            begin
                lx_reg <= lsx_reg ? lx_reg + 13'sd1 : lx_reg - 13'sd1;
            end
            if (le2 < 14'(ldx_reg))
            begin
                ly_reg <= lsy_reg ? ly_reg + 13'sd1 : ly_reg - 13'sd1;
            end
        end
    end

    // midpoint circle stepper
    logic signed [12:0] cf_a, cddy_a, cpy_a;
    always_comb
    begin
        cf_a   = cf_reg;
        cddy_a = cddy_reg;
        cpy_a  = cpy_reg;
        if (cf_reg >= 0)
        begin
            cpy_a  = cpy_reg - 13'sd1;
            cddy_a = cddy_reg + 13'sd2;
            cf_a   = cf_reg + cddy_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.circ_init)
        begin
            cf_reg   <= 13'sd1 - 13'(rad_reg);
            cddx_reg <= 13'sd1;
            cddy_reg <= -(13'(rad_reg) <<< 1);
            cpx_reg  <= '0;
            cpy_reg  <= 13'(rad_reg);
        end
        else if (cmd.circ_step)
        begin
            cpy_reg  <= cpy_a;
            cddy_reg <= cddy_a;
            cpx_reg  <= cpx_reg + 13'sd1;
            cddx_reg <= cddx_reg + 13'sd2;
            cf_reg   <= cf_a + cddx_reg + 13'sd2;
        end
    end

    // read result: data is registered with the strobe at done, zero unless a read of a valid index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_reg      <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_go;
            strobe_reg  <= cmd.done;
            if (cmd.done)
            begin
                if (kind_reg == KIND_READ && 32'(bidx_reg) < 32'(BYTES))
                begin
                    rd_reg <= rdat_reg;
                end
                else
                begin
                    rd_reg <= 8'h00;
                end
            end
        end
    end

    assign read_data = rd_reg;
    assign strobe    = strobe_reg;

    always_comb
    begin
        stat           = '0;
        stat.clr_last  = (clr_reg == '0);
        stat.span_busy = sp_act_reg;
        stat.pix_busy  = pw_busy || rd_pend_reg;
        stat.line_last = (lx_reg == xb_reg) && (ly_reg == yb_reg);
        stat.circ_more = cpx_reg < cpy_reg;
        stat.cpx       = cpx_reg;
        stat.cpy       = cpy_reg;
        stat.cx        = xa_reg;
        stat.cy        = ya_reg;
        stat.xa        = xa_reg;
        stat.ya        = ya_reg;
        stat.w         = w_reg;
        stat.h         = h_reg;
        stat.kind      = kind_reg;
    end

    // no pixel write happens while the clear sweep runs
    a_no_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
        (clr_reg != '0) |-> !pw_act_reg)
        else $error("pixel write during clear sweep");
    a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |=> !strobe_reg)
        else $error("strobe held two cycles");
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && kind_reg != KIND_READ) |-> (rd_reg == 8'h00))
        else $error("nonzero data for drawing command");

endmodule

FILE: hdl/fbre_ctrl.sv
// ----------------------------------------------------------------------------
// fbre_ctrl: command sequencer
// Walks each command through its primitives: clear sweep, pixel ops, line
// steps, rectangle and circle spans, glyph scan and byte read.
// ----------------------------------------------------------------------------
module fbre_ctrl
    import fbre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output fbre_cmd_t   cmd,
    input  fbre_stat_t  stat
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_LINE  = 4'd4;
    localparam logic [3:0] S_SPAN  = 4'd5;
    localparam logic [3:0] S_CSTEP = 4'd6;
    localparam logic [3:0] S_CSPAN = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_RECT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [8:0] idx_reg, idx_next;   // sub-span counter (rect row / edge, circle span)

    logic idle_pix;
    assign idle_pix = !stat.pix_busy && !stat.span_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    logic signed [12:0] cx, cy, px, py;
    logic               fill;
    assign cx   = stat.cx;
    assign cy   = stat.cy;
    assign px   = stat.cpx;
    assign py   = stat.cpy;
    assign fill = (stat.kind == KIND_FCIRCLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next = '0;
                case (stat.kind)
                    KIND_CLEAR:
                    begin
                        cmd.clr_init = 1'b1;
                        state_next   = S_CLR;
                    end
                    KIND_SET, KIND_RESET:
                    begin
                        cmd.px_go  = 1'b1;
                        cmd.px_on  = (stat.kind == KIND_SET);
                        cmd.sx     = stat.xa;
                        cmd.sy     = stat.ya;
                        state_next = S_WAIT;
                    end
                    KIND_LINE:
                    begin
                        cmd.line_init = 1'b1;
                        state_next    = S_LINE;
                    end
                    KIND_RECT, KIND_FRECT:
                    begin
                        state_next = (stat.w == '0 || stat.h == '0) ? S_DONE : S_RECT;
                    end
                    KIND_CIRCLE, KIND_FCIRCLE:
                    begin
                        cmd.circ_init = 1'b1;
                        state_next    = S_CSPAN;
                    end
                    KIND_GLYPH:
                    begin
                        cmd.span_go   = 1'b1;
                        cmd.span_mode = SPAN_G;
                        cmd.sx        = stat.xa;
                        cmd.sy        = stat.ya;
                        cmd.slen      = 11'd40;
                        state_next    = S_WAIT;
                    end
                    KIND_READ:
                    begin
                        cmd.rd_go  = 1'b1;
                        state_next = S_WAIT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CLR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_LINE:
            begin
                if (!stat.pix_busy)
                begin
                    cmd.line_step = 1'b1;
                    if (stat.line_last)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_RECT:
            begin
                // filled: a row for each index; outline: top, bottom, left and right edges
                if (idle_pix)
                begin
                    cmd.span_go = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    if (stat.kind == KIND_FRECT)
                    begin
                        cmd.span_mode = SPAN_H;
                        cmd.sx        = stat.xa;
                        cmd.sy        = stat.ya + 13'(idx_reg);
                        cmd.slen      = 11'(stat.w);
                        if (idx_reg == stat.h - 1'b1)
                        begin
                            state_next = S_WAIT;
                        end
                    end
                    else
                    begin
                        case (idx_reg[1:0])
                            2'd0:
                            begin
                                cmd.span_mode = SPAN_H;
                                cmd.sx = stat.xa;
                                cmd.sy = stat.ya;
                                cmd.slen = 11'(stat.w);
                            end
                            2'd1:
                            begin
                                cmd.span_mode = SPAN_H;
                                cmd.sx = stat.xa;
                                cmd.sy = stat.ya + 13'(stat.h) - 13'sd1;
                                cmd.slen = 11'(stat.w);
                            end
                            2'd2:
                            begin
                                cmd.span_mode = SPAN_V;
                                cmd.sx = stat.xa;
                                cmd.sy = stat.ya;
                                cmd.slen = 11'(stat.h);
                            end
                            default:
                            begin
                                cmd.span_mode = SPAN_V;
                                cmd.sx = stat.xa + 13'(stat.w) - 13'sd1;
                                cmd.sy = stat.ya;
                                cmd.slen = 11'(stat.h);
                                state_next = S_WAIT;
                            end
                        endcase
                    end
                end
            end
            S_CSPAN:
            begin
                // points or spans of the current octant set
                if (idle_pix)
                begin
                    cmd.span_go   = 1'b1;
                    cmd.span_mode = SPAN_V;
                    cmd.slen      = 11'd1;
                    idx_next      = idx_reg + 1'b1;
                    if (fill)
                    begin
                        case (idx_reg[1:0])
                            2'd0:
                            begin
                                cmd.sx = cx + px; cmd.sy = cy - py;
                                cmd.slen = 11'((py <<< 1) + 13'sd1);
                            end
                            2'd1:
                            begin
                                cmd.sx = cx - px; cmd.sy = cy - py;
                                cmd.slen = 11'((py <<< 1) + 13'sd1);
                            end
                            2'd2:
                            begin
                                cmd.sx = cx + py; cmd.sy = cy - px;
                                cmd.slen = 11'((px <<< 1) + 13'sd1);
                            end
                            default:
                            begin
                                cmd.sx = cx - py; cmd.sy = cy - px;
                                cmd.slen = 11'((px <<< 1) + 13'sd1);
                            end
                        endcase
                        if (idx_reg[1:0] == 2'd3 || (px == 0 && idx_reg[1:0] == 2'd0))
                        begin
                            idx_next   = '0;
                            state_next = S_CSTEP;
                        end
                    end
                    else
                    begin
                        case (idx_reg[2:0])
                            3'd0: begin cmd.sx = cx + px; cmd.sy = cy + py; end
                            3'd1: begin cmd.sx = cx - px; cmd.sy = cy + py; end
                            3'd2: begin cmd.sx = cx + px; cmd.sy = cy - py; end
                            3'd3: begin cmd.sx = cx - px; cmd.sy = cy - py; end
                            3'd4: begin cmd.sx = cx + py; cmd.sy = cy + px; end
                            3'd5: begin cmd.sx = cx - py; cmd.sy = cy + px; end
                            3'd6: begin cmd.sx = cx + py; cmd.sy = cy - px; end
                            default: begin cmd.sx = cx - py; cmd.sy = cy - px; end
                        endcase
                        // initial four points: (0,r),(0,-r),(r,0),(-r,0) are idx 0,2,4,5
                        if (px == 0)
                        begin
                            if (idx_reg[2:0] == 3'd0)      idx_next = 9'd2;
                            else if (idx_reg[2:0] == 3'd2) idx_next = 9'd4;
                        end
                        if (idx_reg[2:0] == 3'd7 || (px == 0 && idx_reg[2:0] == 3'd5))
                        begin
                            idx_next   = '0;
                            state_next = S_CSTEP;
                        end
                    end
                end
            end
            S_CSTEP:
            begin
                if (idle_pix)
                begin
                    if (stat.circ_more)
                    begin
                        cmd.circ_step = 1'b1;
                        state_next    = S_CSPAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WAIT:
            begin
                if (idle_pix)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load) |-> (state_reg == S_IDLE))
        else $error("load outside idle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |=> !busy)
        else $error("not idle after done");
    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.line_step |-> !stat.pix_busy)
        else $error("line step over a pending write");

endmodule
